/* src/agz_pkg.sv */
package agz_pkg;

    localparam int GAIN_COUNT = 4;
    localparam int GAIN_W     = $clog2(GAIN_COUNT);
    localparam logic [GAIN_W-1:0] GAIN_MAX = GAIN_W'(GAIN_COUNT - 1);

    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_MODE = 2'd1;
    localparam logic [1:0] CMD_GAIN = 2'd2;

    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_AUTO  = 2'd1;
    localparam logic [1:0] MODE_CALIB = 2'd2;

    localparam logic [2:0] REG_MIN_CORRECTED = 3'd0;
    localparam logic [2:0] REG_WINDOW_BOTTOM = 3'd1;
    localparam logic [2:0] REG_WINDOW_TOP    = 3'd2;
    localparam logic [2:0] REG_DEAD_TIME     = 3'd3;
    localparam logic [2:0] REG_CALIB_DWELL   = 3'd4;
    localparam logic [2:0] REG_MODE_AFTER    = 3'd5;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 24;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [15:0] sample_mv;
        logic [15:0]        elapsed_ms;
        logic [1:0]         new_mode;
        logic [1:0]         new_gain;
    } in_item_t;

    typedef struct packed {
        logic               gain_decision;
        logic [1:0]         calib_step;
        logic signed [15:0] active_mv;
        logic               relay_calibrate;
        logic [1:0]         mode;
        logic [1:0]         gain;
    } result_t;

endpackage

/* src/agz_core.sv */
module agz_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               take,
    input  agz_pkg::in_item_t  item,
    output agz_pkg::result_t   result
);

    logic signed [15:0] min_corrected_reg;
    logic signed [15:0] window_bottom_reg;
    logic signed [15:0] window_top_reg;
    logic [15:0]        dead_time_reg;
    logic [15:0]        calib_dwell_reg;
    logic               mode_after_reg;

    logic [agz_pkg::GAIN_W-1:0] gain_reg, gain_next;
    logic [1:0]                 mode_reg, mode_next;
    logic [agz_pkg::GAIN_W-1:0] calib_step_reg, calib_step_next;
    logic [16:0]                calib_clock_reg, calib_clock_next;
    logic [15:0]                holdoff_reg, holdoff_next;
    logic                       relay_reg, relay_next;
    logic signed [15:0] zero_store_reg [agz_pkg::GAIN_COUNT];
    logic signed [15:0] zero_store_next [agz_pkg::GAIN_COUNT];
    logic signed [15:0] corr_store_reg [agz_pkg::GAIN_COUNT];
    logic signed [15:0] corr_store_next [agz_pkg::GAIN_COUNT];

    logic signed [16:0] diff;
    logic signed [15:0] corrected;
    logic               decision;

    // Sample minus the zero offset of the current gain, saturated to 16 bits.
    assign diff = {item.sample_mv[15], item.sample_mv}
                - {zero_store_reg[gain_reg][15], zero_store_reg[gain_reg]};
    always_comb
    begin
        if (diff[16] != diff[15])
        begin
            corrected = diff[16] ? 16'sh8000 : 16'sh7FFF;
        end
        else
        begin
            corrected = diff[15:0];
        end
    end

    always_comb
    begin
        gain_next        = gain_reg;
        mode_next        = mode_reg;
        calib_step_next  = calib_step_reg;
        calib_clock_next = calib_clock_reg;
        holdoff_next     = holdoff_reg;
        relay_next       = relay_reg;
        zero_store_next  = zero_store_reg;
        corr_store_next  = corr_store_reg;
        decision         = 1'b0;
        if (take)
        begin
            unique case (item.command)
                agz_pkg::CMD_TICK:
                begin
                    corr_store_next[gain_reg] = corrected;
                    if (mode_reg == agz_pkg::MODE_AUTO)
                    begin
                        // The tick that brings the hold-off to zero makes no check.
                        if (holdoff_reg != 16'd0)
                        begin
                            holdoff_next = (holdoff_reg > item.elapsed_ms)
                                         ? holdoff_reg - item.elapsed_ms : 16'd0;
                        end
                        else if (corrected <= min_corrected_reg)
                        begin
                            if (gain_reg < agz_pkg::GAIN_MAX)
                            begin
                                gain_next = gain_reg + 1'b1;
                            end
                            decision     = 1'b1;
                            holdoff_next = dead_time_reg;
                        end
                        else if (item.sample_mv < window_bottom_reg
                                 || item.sample_mv > window_top_reg)
                        begin
                            if (gain_reg != '0)
                            begin
                                gain_next = gain_reg - 1'b1;
                            end
                            decision     = 1'b1;
                            holdoff_next = dead_time_reg;
                        end
                    end
                    else if (mode_reg == agz_pkg::MODE_CALIB)
                    begin
                        gain_next  = calib_step_reg;
                        relay_next = 1'b1;
                        if (calib_clock_reg >= {1'b0, calib_dwell_reg})
                        begin
                            calib_clock_next                = '0;
                            zero_store_next[calib_step_reg] = item.sample_mv;
                            if (calib_step_reg == '0)
                            begin
                                mode_next  = {1'b0, mode_after_reg};
                                gain_next  = '0;
                                relay_next = 1'b0;
                            end
                            else
                            begin
                                calib_step_next = calib_step_reg - 1'b1;
                            end
                        end
                        else
                        begin
                            calib_clock_next = calib_clock_reg + {1'b0, item.elapsed_ms};
                        end
                    end
                end
                agz_pkg::CMD_MODE:
                begin
                    if (item.new_mode <= agz_pkg::MODE_CALIB)
                    begin
                        mode_next = item.new_mode;
                        if (item.new_mode == agz_pkg::MODE_CALIB)
                        begin
                            calib_step_next = agz_pkg::GAIN_MAX;
                        end
                    end
                end
                agz_pkg::CMD_GAIN:
                begin
                    gain_next = (item.new_gain > agz_pkg::GAIN_MAX)
                              ? agz_pkg::GAIN_MAX : item.new_gain;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        result.gain            = gain_next;
        result.mode            = mode_next;
        result.relay_calibrate = relay_next;
        result.active_mv       = corr_store_next[gain_next];
        result.calib_step      = calib_step_next;
        result.gain_decision   = decision;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_corrected_reg <= 16'sd10;
            window_bottom_reg <= 16'sd100;
            window_top_reg    <= 16'sd3200;
            dead_time_reg     <= 16'd1000;
            calib_dwell_reg   <= 16'd1000;
            mode_after_reg    <= 1'b1;
            gain_reg          <= '0;
            mode_reg          <= agz_pkg::MODE_CALIB;
            calib_step_reg    <= agz_pkg::GAIN_MAX;
            calib_clock_reg   <= '0;
            holdoff_reg       <= 16'd1000;
            relay_reg         <= 1'b0;
            for (int i = 0; i < agz_pkg::GAIN_COUNT; i++)
            begin
                zero_store_reg[i] <= '0;
                corr_store_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    agz_pkg::REG_MIN_CORRECTED: min_corrected_reg <= cfg_data;
                    agz_pkg::REG_WINDOW_BOTTOM: window_bottom_reg <= cfg_data;
                    agz_pkg::REG_WINDOW_TOP:    window_top_reg    <= cfg_data;
                    agz_pkg::REG_DEAD_TIME:     dead_time_reg     <= cfg_data;
                    agz_pkg::REG_CALIB_DWELL:   calib_dwell_reg   <= cfg_data;
                    agz_pkg::REG_MODE_AFTER:    mode_after_reg    <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
            gain_reg        <= gain_next;
            mode_reg        <= mode_next;
            calib_step_reg  <= calib_step_next;
            calib_clock_reg <= calib_clock_next;
            holdoff_reg     <= holdoff_next;
            relay_reg       <= relay_next;
            zero_store_reg  <= zero_store_next;
            corr_store_reg  <= corr_store_next;
        end
    end

endmodule

/* src/autorange_gain_with_zero_calibration.sv */
// Auto-ranging gain controller with zero-offset calibration for one sensor channel.
// Input stream (s_axis_*): one transaction per command. tuser carries the command
// (tick with sample, set mode, set gain); tdata carries sample, elapsed time and
// the new mode or gain. Output stream (m_axis_*): exactly one status transaction
// per input transaction, in order: gain, mode, relay, corrected voltage of the
// current gain, calibration step and the auto-range decision flag.
// Configuration (cfg_*): register index and 16-bit data; always ready. Write only
// while no transaction is in flight.
// The state updates at the input transaction and the status lands in the output
// register on the same edge. Throughput is one transaction per cycle;
// s_axis_tready stays high while the output register is empty or being taken,
// so a stalled receiver holds one status and then backpressures the input.
// After reset the block is in calibration mode at the top gain step, the relay is
// on measurement, the stored offsets and corrected values are zero, and the
// configuration registers hold their default values.
module autorange_gain_with_zero_calibration (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [15:0] sample_mv, [31:16] elapsed_ms, [33:32] new_mode, [35:34] new_gain
    input  logic [agz_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [1:0] command
    input  logic [1:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [1:0] gain, [3:2] mode, [4] relay_calibrate, [20:5] active_mv,
    // [22:21] calib_step, [23] gain_decision
    output logic [agz_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [2:0]                       cfg_index,
    input  logic [15:0]                      cfg_data
);

    agz_pkg::in_item_t item;
    agz_pkg::result_t  result;
    logic              take;
    logic              out_valid_reg;
    agz_pkg::result_t  out_data_reg;

    assign item.command   = s_axis_tuser;
    assign item.sample_mv = s_axis_tdata[15:0];
    assign item.elapsed_ms = s_axis_tdata[31:16];
    assign item.new_mode  = s_axis_tdata[33:32];
    assign item.new_gain  = s_axis_tdata[35:34];

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign take          = s_axis_tvalid && s_axis_tready;

    agz_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .take      (take),
        .item      (item),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_data_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

/* src/agz_checker.sv */
module agz_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [agz_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    // A held status transaction stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("status transaction dropped while stalled");

    // A held status transaction keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("status payload changed while stalled");

    // With the output register empty the input side must be open.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output register");

    // A range decision is only made in auto mode.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[23] |-> m_axis_tdata[3:2] == agz_pkg::MODE_AUTO)
        else $error("gain decision reported outside auto mode");

endmodule

bind autorange_gain_with_zero_calibration agz_checker u_agz_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
